>>> src/bbs_pkg.sv
// Shared constants and handshake types for the BBS bit generator.
// No dependencies; used by bbs_sqr_unit and the top level.
package bbs_pkg;

  // Default arithmetic width.
  localparam int MOD_BITS_DEF = 32;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd1;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] MODULUS_RESET = 32'd1050589;
  localparam logic [CFG_DATA_W-1:0] SEED_RESET    = 32'd1000;

  // Request from the control FSM to the squaring unit.
  typedef struct packed {
    logic start;   // load operand and begin
    logic reduce;  // operand not below modulus: reduce it first
  } bbs_req_t;

  // Status from the squaring unit.
  typedef struct packed {
    logic busy;    // a reduction or multiplication is in progress
    logic done;    // one-cycle pulse, result valid
  } bbs_sts_t;

endpackage

>>> src/bbs_sqr_unit.sv
// Bit-serial modular squaring unit: result = operand^2 mod modulus.
// Scans operand bits MSB first, one bit per cycle; depends on bbs_pkg.
module bbs_sqr_unit #(
  parameter int MOD_BITS = bbs_pkg::MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bbs_pkg::bbs_req_t   req,
  input  logic [MOD_BITS-1:0] operand,
  input  logic [MOD_BITS-1:0] modulus,
  output bbs_pkg::bbs_sts_t   sts,
  output logic [MOD_BITS-1:0] result
);

  localparam int CntW = $clog2(MOD_BITS);
  localparam int SumW = MOD_BITS + 2;
  localparam logic [CntW-1:0] LastCnt = CntW'(MOD_BITS - 1);

  typedef enum logic [1:0] {PH_IDLE, PH_REDUCE, PH_MUL} phase_t;

  phase_t              phase;
  logic [CntW-1:0]     cnt;
  logic [MOD_BITS-1:0] shreg;
  logic [MOD_BITS-1:0] opnd;
  logic [MOD_BITS-1:0] addend;
  logic [MOD_BITS-1:0] acc;
  logic                done;

  logic                bit_in;
  logic [SumW-1:0]     add_val;
  logic [SumW-1:0]     sum;
  logic [SumW-1:0]     mod1;
  logic [SumW-1:0]     mod2;
  logic [SumW-1:0]     red;
  logic [MOD_BITS-1:0] acc_next;

  // One step: acc = (2*acc + bit*addend) mod m, with sum below 3m.
  // Reduction phase feeds the operand bits in as the addend of one.
  always_comb begin
    bit_in  = shreg[MOD_BITS-1];
    add_val = (phase == PH_REDUCE) ? SumW'(1) : {2'b00, addend};
    sum     = {1'b0, acc, 1'b0} + (bit_in ? add_val : '0);
    mod1    = {2'b00, modulus};
    mod2    = {1'b0, modulus, 1'b0};
    if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
    acc_next = red[MOD_BITS-1:0];
  end

  // Sequence the reduce and multiply passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            cnt    <= LastCnt;
            acc    <= '0;
            shreg  <= operand;
            opnd   <= operand;
            addend <= operand;
            phase  <= req.reduce ? PH_REDUCE : PH_MUL;
          end
        end
        PH_REDUCE: begin
          done <= 1'b0;
          if (cnt == '0) begin
            // operand mod m becomes the multiplicand; rescan the operand
            addend <= acc_next;
            acc    <= '0;
            shreg  <= opnd;
            cnt    <= LastCnt;
            phase  <= PH_MUL;
          end else begin
            acc   <= acc_next;
            shreg <= shreg << 1;
            cnt   <= cnt - 1'b1;
          end
        end
        PH_MUL: begin
          acc   <= acc_next;
          shreg <= shreg << 1;
          cnt   <= cnt - 1'b1;
          done  <= (cnt == '0);
          if (cnt == '0) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  assign result   = acc;
  assign sts.done = done;
  assign sts.busy = (phase != PH_IDLE);

endmodule

>>> src/blum_blum_shub_bit_generator_unit.sv
// Blum Blum Shub bit generator: one key bit and the next state per request.
// Each request runs through the bit-serial squaring unit, preceded by a reduction pass
// when the state is not below the modulus (after restart or a modulus change); with
// modulus 0 the unit is bypassed and the new state is 0. One request is in flight at a time.
// Reset (synchronous): modulus 1050589, seed 1000, state 1000, no result pending.
// Depends on bbs_pkg and bbs_sqr_unit.
module blum_blum_shub_bit_generator_unit #(
  parameter int MOD_BITS = bbs_pkg::MOD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           key_bit,
  output logic [31:0]                    state_value,
  input  logic                           cfg_we,
  input  logic [bbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbs_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

  state_t                         state;
  logic [bbs_pkg::CFG_DATA_W-1:0] modulus;
  logic [bbs_pkg::CFG_DATA_W-1:0] seed;
  logic [MOD_BITS-1:0]            cur;
  logic                           key_hold;

  logic [MOD_BITS-1:0]            m_w;
  logic [MOD_BITS-1:0]            x;
  logic                           in_fire;
  bbs_pkg::bbs_req_t              req;
  bbs_pkg::bbs_sts_t              sts;
  logic [MOD_BITS-1:0]            sq_result;

  // Working modulus and the state this request starts from.
  assign m_w      = MOD_BITS'(modulus);
  assign x        = restart ? MOD_BITS'(seed) : cur;
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign req.start  = in_fire && (m_w != '0);
  assign req.reduce = (x >= m_w);

  bbs_sqr_unit #(
    .MOD_BITS (MOD_BITS)
  ) u_sqr (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .operand (x),
    .modulus (m_w),
    .sts     (sts),
    .result  (sq_result)
  );

  // Configuration registers; ignore indexes beyond the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= bbs_pkg::MODULUS_RESET;
      seed    <= bbs_pkg::SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbs_pkg::REG_MODULUS: modulus <= cfg_data;
        bbs_pkg::REG_SEED:    seed    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request control, state update and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cur       <= MOD_BITS'(bbs_pkg::SEED_RESET);
    end else begin
      // drop the result once the transaction completes
      if (out_ready && state != ST_HOLD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            key_hold <= x[0];
            if (m_w == '0) begin
              cur   <= '0;
              state <= ST_HOLD;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (sts.done) begin
            cur   <= sq_result;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            key_bit     <= key_hold;
            state_value <= 32'(cur);
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on control sequencing and the arithmetic result.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("request accepted while previous request in flight");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (state == ST_RUN))
    else $error("squaring unit finished outside of run state");

  a_state_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && sts.done) |=> (cur < m_w))
    else $error("new state not below modulus");

  a_zero_modulus: assert property (@(posedge clk) disable iff (rst)
    (in_fire && m_w == '0) |=> (cur == '0 && state == ST_HOLD))
    else $error("zero modulus did not give zero state");

  a_unit_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (sts.busy || sts.done))
    else $error("run state with squaring unit idle");

endmodule
